FILE: rtl/poi_pkg.sv
package poi_pkg;

   // field widths
   localparam int POS_W        = 32;
   localparam int ANG_W        = 24;
   localparam int SPEED_W      = 16;
   localparam int PERIOD_W     = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   // cordic and multiplier sizing
   localparam int CORDIC_STEPS = 28;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int PHASE_W      = 32;
   localparam int MUL_W        = 33;
   localparam int PROD_W       = 2 * MUL_W;

   // rounding points of the products
   localparam int DTH_SHIFT    = 60 - ANG_W;
   localparam int HALF_SHIFT   = 61 - ANG_W;
   localparam int POS_SHIFT    = 42;

   localparam logic signed [MUL_W-1:0] TURNS_PER_RADIAN = 33'sd683565276;
   localparam logic signed [MUL_W-1:0] CORDIC_GAIN      = 33'sd652032874;
   localparam logic [PERIOD_W-1:0]     PERIOD_RESET     = 16'd6554;

   typedef enum logic [1:0] {
      OP_VELOCITY = 2'd0,
      OP_RECENTER = 2'd1,
      OP_SET_POSE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE   = 1'b0,
      CSR_PERIOD = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type                  opcode;
      logic signed [SPEED_W-1:0]   linear_speed;
      logic signed [SPEED_W-1:0]   turn_rate;
      logic signed [POS_W-1:0]     new_x;
      logic signed [POS_W-1:0]     new_y;
      logic signed [ANG_W-1:0]     new_heading;
   } req_payload_type;

   typedef struct packed {
      logic signed [POS_W-1:0]     pos_x;
      logic signed [POS_W-1:0]     pos_y;
      logic signed [ANG_W-1:0]     heading;
      logic signed [SPEED_W-1:0]   echo_linear;
      logic signed [SPEED_W-1:0]   echo_angular;
      logic                        method_used;
   } rsp_payload_type;

   // arctangent of 2^-i in 32-bit turn units
   function automatic logic [PHASE_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
      logic [PHASE_W-1:0] v;
      case (i)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/poi_if.sv
interface poi_req_if import poi_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface poi_rsp_if import poi_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/planar_odometry_integrator.sv
// Planar pose integrator (x, y, heading) driven by velocity samples.
// req_port carries commands: a velocity sample, a recenter or a set-pose.
// rsp_port returns one pose transfer per velocity sample; recenter and
// set-pose update the pose in the accept cycle and give no transfer.
// csr_* writes integration_mode (index 0) and sample_period (index 1);
// write only while the block is idle.
// A velocity sample, once accepted, runs through one shared 33x33
// multiplier (step, turn rate, turn scaling, x, y products) and one
// 28-step CORDIC shift-add unit; the result is then registered.
// req_port.ready rises in the cycle the result is presented, so a new
// velocity sample is taken only after the previous one is done; recenter
// and set-pose complete in the accept cycle and leave ready high.
// While a sample is in work req_port.ready is low. The result sits in an
// output register, so new commands are accepted while it waits; a sample
// that finishes before the previous result is taken holds in its last step.
// Reset (synchronous, active high) zeroes the pose, sets Euler mode and a
// period of 6554 (about 0.1 s), and drops any pending result.
module planar_odometry_integrator import poi_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   poi_req_if.sink                 req_port,
   poi_rsp_if.source               rsp_port,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_MUL_STEP  = 11'b000_0000_0010,
      ST_MUL_TURN  = 11'b000_0000_0100,
      ST_MUL_TURNK = 11'b000_0000_1000,
      ST_ANGLE     = 11'b000_0001_0000,
      ST_CORDIC    = 11'b000_0010_0000,
      ST_QUAD      = 11'b000_0100_0000,
      ST_MUL_X     = 11'b000_1000_0000,
      ST_MUL_Y     = 11'b001_0000_0000,
      ST_UPDATE    = 11'b010_0000_0000,
      ST_DONE      = 11'b100_0000_0000
   } state_type;

   localparam logic signed [PROD_W-1:0] DTH_HALF  = PROD_W'(1) << (DTH_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] RK_HALF   = PROD_W'(1) << (HALF_SHIFT - 1);
   localparam logic signed [PROD_W-1:0] POS_HALF  = PROD_W'(1) << (POS_SHIFT - 1);
   localparam logic [PHASE_W-1:0]       QUAD_BIAS = PHASE_W'(1) << (PHASE_W - 3);
   localparam logic signed [POS_W+1:0]  POS_MAX   = (POS_W+2)'((64'd1 << (POS_W - 1)) - 1);
   localparam logic signed [POS_W+1:0]  POS_MIN   = -POS_MAX - (POS_W+2)'(1);

   // saturate a widened position sum
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > POS_MAX) begin
         r = POS_MAX[POS_W-1:0];
      end else if (v < POS_MIN) begin
         r = POS_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   state_type                  state_ff, state_in;
   logic                       mode_ff;
   logic [PERIOD_W-1:0]        period_ff;
   logic signed [POS_W-1:0]    pose_x_ff, pose_x_in;
   logic signed [POS_W-1:0]    pose_y_ff, pose_y_in;
   logic [ANG_W-1:0]           pose_heading_ff, pose_heading_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_data_ff;

   logic signed [SPEED_W-1:0]  lin_ff;
   logic signed [SPEED_W-1:0]  ang_ff;
   logic                       method_ff;
   logic signed [MUL_W-1:0]    step_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [ANG_W-1:0]           dth_ff;
   logic [1:0]                 quad_ff;
   logic signed [MUL_W-1:0]    x_ff;
   logic signed [MUL_W-1:0]    y_ff;
   logic signed [MUL_W-1:0]    z_ff;
   logic [ITER_W-1:0]          iter_ff;

   logic                       req_xfer;
   logic                       out_free;
   logic signed [MUL_W-1:0]    mul_a;
   logic signed [MUL_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   dth_sum;
   logic signed [PROD_W-1:0]   rk_sum;
   logic signed [PROD_W-1:0]   pos_sum;
   logic signed [POS_W+1:0]    pos_delta;
   logic [ANG_W-1:0]           angle;
   logic [PHASE_W-1:0]         phase;
   logic [PHASE_W-1:0]         phase_biased;
   logic [PHASE_W-1:0]         z_start;
   logic signed [MUL_W-1:0]    x_shift;
   logic signed [MUL_W-1:0]    y_shift;
   logic signed [MUL_W-1:0]    atan_ext;

   assign req_xfer       = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.data  = rsp_data_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_STEP: begin
            mul_a = {{(MUL_W-SPEED_W){lin_ff[SPEED_W-1]}}, lin_ff};
            mul_b = {{(MUL_W-PERIOD_W){1'b0}}, period_ff};
         end
         ST_MUL_TURN: begin
            mul_a = {{(MUL_W-SPEED_W){ang_ff[SPEED_W-1]}}, ang_ff};
            mul_b = {{(MUL_W-PERIOD_W){1'b0}}, period_ff};
         end
         ST_MUL_TURNK: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = TURNS_PER_RADIAN;
         end
         ST_MUL_X: begin
            mul_a = step_ff;
            mul_b = x_ff;
         end
         ST_MUL_Y: begin
            mul_a = step_ff;
            mul_b = y_ff;
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // heading increment rounding and cordic start phase
   assign dth_sum      = prod_ff + DTH_HALF;
   assign rk_sum       = prod_ff + RK_HALF;
   assign angle        = method_ff ? pose_heading_ff + rk_sum[HALF_SHIFT +: ANG_W]
                                   : pose_heading_ff;
   assign phase        = {angle, {(PHASE_W-ANG_W){1'b0}}};
   assign phase_biased = phase + QUAD_BIAS;
   assign z_start      = phase - {phase_biased[PHASE_W-1 -: 2], {(PHASE_W-2){1'b0}}};

   // cordic micro-rotation operands
   assign x_shift  = x_ff >>> iter_ff;
   assign y_shift  = y_ff >>> iter_ff;
   assign atan_ext = {{(MUL_W-PHASE_W){1'b0}}, atan_turn(iter_ff)};

   // rounded position delta from the product register
   assign pos_sum   = prod_ff + POS_HALF;
   assign pos_delta = (POS_W+2)'($signed(pos_sum[PROD_W-1:POS_SHIFT]));

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_port.data.opcode == OP_VELOCITY) begin
               state_in = ST_MUL_STEP;
            end
         end
         ST_MUL_STEP:  state_in = ST_MUL_TURN;
         ST_MUL_TURN:  state_in = ST_MUL_TURNK;
         ST_MUL_TURNK: state_in = ST_ANGLE;
         ST_ANGLE:     state_in = ST_CORDIC;
         ST_CORDIC: begin
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_QUAD;
            end
         end
         ST_QUAD:      state_in = ST_MUL_X;
         ST_MUL_X:     state_in = ST_MUL_Y;
         ST_MUL_Y:     state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // pose update
   always_comb begin
      pose_x_in       = pose_x_ff;
      pose_y_in       = pose_y_ff;
      pose_heading_in = pose_heading_ff;
      if (req_xfer) begin
         case (req_port.data.opcode)
            OP_RECENTER: begin
               pose_x_in       = '0;
               pose_y_in       = '0;
               pose_heading_in = '0;
            end
            OP_SET_POSE: begin
               pose_x_in       = POS_W'(req_port.data.new_x);
               pose_y_in       = POS_W'(req_port.data.new_y);
               pose_heading_in = ANG_W'(req_port.data.new_heading);
            end
            default: begin
            end
         endcase
      end
      if (state_ff == ST_MUL_Y) begin
         pose_x_in = sat_pos((POS_W+2)'(pose_x_ff) + pos_delta);
      end
      if (state_ff == ST_UPDATE) begin
         pose_y_in       = sat_pos((POS_W+2)'(pose_y_ff) + pos_delta);
         pose_heading_in = pose_heading_ff + dth_ff;
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state, configuration and pose
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= 1'b0;
         period_ff       <= PERIOD_RESET;
         pose_x_ff       <= '0;
         pose_y_ff       <= '0;
         pose_heading_ff <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         pose_x_ff       <= pose_x_in;
         pose_y_ff       <= pose_y_in;
         pose_heading_ff <= pose_heading_in;
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_MODE:   mode_ff   <= csr_write_data[0];
               CSR_PERIOD: period_ff <= csr_write_data[PERIOD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (req_xfer) begin
         lin_ff    <= req_port.data.linear_speed;
         ang_ff    <= req_port.data.turn_rate;
         method_ff <= mode_ff;
      end
      if (state_ff == ST_MUL_TURN) begin
         step_ff <= prod_ff[MUL_W-1:0];
      end
      if (state_ff == ST_ANGLE) begin
         dth_ff  <= dth_sum[DTH_SHIFT +: ANG_W];
         quad_ff <= phase_biased[PHASE_W-1 -: 2];
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= {{(MUL_W-PHASE_W){z_start[PHASE_W-1]}}, z_start};
         iter_ff <= '0;
      end
      if (state_ff == ST_CORDIC) begin
         iter_ff <= iter_ff + ITER_W'(1);
         if (!z_ff[MUL_W-1]) begin
            x_ff <= x_ff - y_shift;
            y_ff <= y_ff + x_shift;
            z_ff <= z_ff - atan_ext;
         end else begin
            x_ff <= x_ff + y_shift;
            y_ff <= y_ff - x_shift;
            z_ff <= z_ff + atan_ext;
         end
      end
      // fold the quadrant back: x becomes cosine, y sine
      if (state_ff == ST_QUAD) begin
         case (quad_ff)
            2'd0: begin
            end
            2'd1: begin
               x_ff <= -y_ff;
               y_ff <= x_ff;
            end
            2'd2: begin
               x_ff <= -x_ff;
               y_ff <= -y_ff;
            end
            default: begin
               x_ff <= y_ff;
               y_ff <= -x_ff;
            end
         endcase
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff.pos_x        <= pose_x_ff;
         rsp_data_ff.pos_y        <= pose_y_ff;
         rsp_data_ff.heading      <= pose_heading_ff;
         rsp_data_ff.echo_linear  <= lin_ff;
         rsp_data_ff.echo_angular <= ang_ff;
         rsp_data_ff.method_used  <= method_ff;
      end
   end

   // checks
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_port.ready)
      else $error("command accepted while a sample is in work");

   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_port.data.opcode == OP_RECENTER)
      |=> (pose_x_ff == '0 && pose_y_ff == '0 && pose_heading_ff == '0))
      else $error("recenter did not clear the pose");

   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_port.data.opcode == OP_VELOCITY) |=> (state_ff == ST_MUL_STEP))
      else $error("velocity sample did not start the sequence");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (iter_ff <= ITER_W'(CORDIC_STEPS - 1)))
      else $error("cordic step count overrun");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

endmodule
